// File: rtl/udprc_pkg.sv
// UDP receive checker package: verdict codes, header constants, the segment
// snapshot and result types, and the ones'-complement adder.
// No dependencies.
package udprc_pkg;

    // Verdict codes given with every result item.
    localparam logic [1:0] VERDICT_ACCEPT   = 2'd0;
    localparam logic [1:0] VERDICT_RUNT     = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LEN  = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CSUM = 2'd3;

    // Header and pseudo-header constants.
    localparam logic [15:0] HDR_BYTES       = 16'd8;
    localparam logic [15:0] PROTO_UDP       = 16'd17;
    localparam logic [15:0] ECHO_PORT_RESET = 16'd7;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    // Byte positions of the header fields.
    localparam logic [15:0] POS_SRC_HI  = 16'd0;
    localparam logic [15:0] POS_SRC_LO  = 16'd1;
    localparam logic [15:0] POS_DST_HI  = 16'd2;
    localparam logic [15:0] POS_DST_LO  = 16'd3;
    localparam logic [15:0] POS_LEN_HI  = 16'd4;
    localparam logic [15:0] POS_LEN_LO  = 16'd5;
    localparam logic [15:0] POS_CSUM_HI = 16'd6;
    localparam logic [15:0] POS_CSUM_LO = 16'd7;

    // Segment state as it stands after its last byte, plus the address sum.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] running_sum;
        logic [7:0]  high_byte_hold;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] hdr_length;
        logic [15:0] hdr_checksum;
        logic [17:0] addr_sum;
    } seg_snap_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] data_len;
        logic        echo_hit;
    } result_t;

    // Ones'-complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: rtl/udprc_parser.sv
// Per-byte segment state of the UDP receive checker: header fields, byte
// counter and running ones'-complement sum. Depends on udprc_pkg.
module udprc_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [31:0]           src_ip,
    input  logic [31:0]           dst_ip,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output udprc_pkg::seg_snap_t  snap
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic [15:0] source_port_reg, source_port_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic [15:0] hdr_length_reg, hdr_length_next;
    logic [15:0] hdr_checksum_reg, hdr_checksum_next;
    logic [7:0]  sum_byte;
    logic        sum_en;

    // Header capture, checksum summing and byte counting for one item.
    always_comb begin
        source_port_next    = source_port_reg;
        dest_port_next      = dest_port_reg;
        hdr_length_next     = hdr_length_reg;
        hdr_checksum_next   = hdr_checksum_reg;
        high_byte_hold_next = high_byte_hold_reg;
        running_sum_next    = running_sum_reg;
        sum_byte            = data_byte;
        case (byte_count_reg)
            udprc_pkg::POS_SRC_HI:  source_port_next = {data_byte, source_port_reg[7:0]};
            udprc_pkg::POS_SRC_LO:  source_port_next = {source_port_reg[15:8], data_byte};
            udprc_pkg::POS_DST_HI:  dest_port_next = {data_byte, dest_port_reg[7:0]};
            udprc_pkg::POS_DST_LO:  dest_port_next = {dest_port_reg[15:8], data_byte};
            udprc_pkg::POS_LEN_HI:  hdr_length_next = {data_byte, hdr_length_reg[7:0]};
            udprc_pkg::POS_LEN_LO:  hdr_length_next = {hdr_length_reg[15:8], data_byte};
            udprc_pkg::POS_CSUM_HI: begin
                hdr_checksum_next = {data_byte, hdr_checksum_reg[7:0]};
                sum_byte          = 8'h00;
            end
            udprc_pkg::POS_CSUM_LO: begin
                hdr_checksum_next = {hdr_checksum_reg[15:8], data_byte};
                sum_byte          = 8'h00;
            end
            default: begin
            end
        endcase

        // Only the header and the bytes the length field covers are summed.
        sum_en = (byte_count_reg < udprc_pkg::HDR_BYTES) || (byte_count_reg < hdr_length_reg);
        if (sum_en) begin
            if (!byte_count_reg[0]) begin
                high_byte_hold_next = sum_byte;
            end else begin
                running_sum_next = udprc_pkg::oc_add(running_sum_reg,
                                                     {high_byte_hold_reg, sum_byte});
            end
        end

        // The counter saturates on very long segments.
        if (byte_count_reg != udprc_pkg::COUNT_MAX) begin
            byte_count_next = byte_count_reg + 16'd1;
        end else begin
            byte_count_next = byte_count_reg;
        end
    end

    // Snapshot of the updated state, used when this item is the last byte.
    always_comb begin
        snap.byte_count     = byte_count_next;
        snap.running_sum    = running_sum_next;
        snap.high_byte_hold = high_byte_hold_next;
        snap.source_port    = source_port_next;
        snap.dest_port      = dest_port_next;
        snap.hdr_length     = hdr_length_next;
        snap.hdr_checksum   = hdr_checksum_next;
        snap.addr_sum       = {2'b00, src_ip[31:16]} + {2'b00, src_ip[15:0]}
                            + {2'b00, dst_ip[31:16]} + {2'b00, dst_ip[15:0]};
    end

    // State advances on each consumed item and clears after a last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            byte_count_reg     <= '0;
            running_sum_reg    <= '0;
            high_byte_hold_reg <= '0;
            source_port_reg    <= '0;
            dest_port_reg      <= '0;
            hdr_length_reg     <= '0;
            hdr_checksum_reg   <= '0;
        end else if (step) begin
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            high_byte_hold_reg <= high_byte_hold_next;
            source_port_reg    <= source_port_next;
            dest_port_reg      <= dest_port_next;
            hdr_length_reg     <= hdr_length_next;
            hdr_checksum_reg   <= hdr_checksum_next;
        end
    end

endmodule

// File: rtl/udprc_verify.sv
// Verdict logic of the UDP receive checker: runt and length checks and the
// pseudo-header checksum verification. Depends on udprc_pkg.
module udprc_verify (
    input  udprc_pkg::seg_snap_t snap,
    input  logic [15:0]          echo_port,
    output udprc_pkg::result_t   res
);

    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] calc;
    logic [15:0] pad_word;
    logic        csum_ok;

    // Ones'-complement sum as a plain sum folded twice; the protocol term
    // keeps it nonzero, so the fold matches the chained end-around adds.
    always_comb begin
        pad_word = snap.hdr_length[0] ? {snap.high_byte_hold, 8'h00} : 16'h0000;
        total    = {3'b000, snap.running_sum} + {3'b000, pad_word}
                 + {1'b0, snap.addr_sum} + {3'b000, udprc_pkg::PROTO_UDP}
                 + {3'b000, snap.hdr_length};
        fold1    = {1'b0, total[15:0]} + {14'd0, total[18:16]};
        fold2    = fold1[15:0] + {15'd0, fold1[16]};
        calc     = ~fold2;
        csum_ok  = (calc == snap.hdr_checksum)
                || ((calc == 16'h0000) && (snap.hdr_checksum == 16'hFFFF));
    end

    // Verdict and reported fields.
    always_comb begin
        res.verdict     = udprc_pkg::VERDICT_ACCEPT;
        res.source_port = snap.source_port;
        res.dest_port   = snap.dest_port;
        res.data_len    = 16'd0;
        res.echo_hit    = 1'b0;
        if (snap.byte_count < udprc_pkg::HDR_BYTES) begin
            res.verdict     = udprc_pkg::VERDICT_RUNT;
            res.source_port = 16'd0;
            res.dest_port   = 16'd0;
        end else if ((snap.hdr_length < udprc_pkg::HDR_BYTES)
                     || (snap.hdr_length > snap.byte_count)) begin
            res.verdict = udprc_pkg::VERDICT_BAD_LEN;
        end else begin
            res.data_len = snap.hdr_length - udprc_pkg::HDR_BYTES;
            if ((snap.hdr_checksum != 16'h0000) && !csum_ok) begin
                res.verdict = udprc_pkg::VERDICT_BAD_CSUM;
            end else begin
                res.echo_hit = (snap.dest_port == echo_port);
            end
        end
    end

endmodule

// File: rtl/udp_receive_checker.sv
// UDP receive checker top level: input register, parser, verdict stage and
// result register. Depends on udprc_pkg, udprc_parser and udprc_verify.
//
// The block takes one segment byte per clock cycle, with no gaps between
// segments, as long as a last byte does not wait. Each byte passes an input
// register and then updates the segment state in the parser. A last byte
// also moves a snapshot of the segment into the verdict stage, whose
// register feeds the result register that offers the result. Ordinary
// bytes never wait on the result channel; a last byte waits only while
// both the verdict stage and the result register are held by earlier
// results. The echo port register resets to 7 and is written through the
// cfg channel, which is always ready.
module udp_receive_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_echo_port,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [15:0] m_source_port,
    output logic [15:0] m_dest_port,
    output logic [15:0] m_data_len,
    output logic        m_echo_hit
);

    logic                 in_valid_reg;
    logic [31:0]          in_src_ip_reg;
    logic [31:0]          in_dst_ip_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 fin_valid_reg;
    udprc_pkg::seg_snap_t fin_snap_reg;
    logic                 out_valid_reg;
    udprc_pkg::result_t   out_res_reg;
    logic [15:0]          echo_port_reg;

    udprc_pkg::seg_snap_t snap;
    udprc_pkg::result_t   res;
    logic                 out_free;
    logic                 fin_move;
    logic                 fin_free;
    logic                 in_step;

    // Stage handshakes: a stage takes a new item when it is empty or moving on.
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        fin_move = fin_valid_reg && out_free;
        fin_free = !fin_valid_reg || out_free;
        in_step  = in_valid_reg && (!in_last_reg || fin_free);
    end

    assign s_ready   = !in_valid_reg || in_step;
    assign cfg_ready = 1'b1;

    // Echo port register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_port_reg <= udprc_pkg::ECHO_PORT_RESET;
        end else if (cfg_valid) begin
            echo_port_reg <= cfg_echo_port;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (in_step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_src_ip_reg <= s_src_ip;
            in_dst_ip_reg <= s_dst_ip;
            in_byte_reg   <= s_data_byte;
            in_last_reg   <= s_last_byte;
        end
    end

    udprc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_step),
        .src_ip    (in_src_ip_reg),
        .dst_ip    (in_dst_ip_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .snap      (snap)
    );

    // Verdict stage register, loaded with the snapshot of a finished segment.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (in_step && in_last_reg) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_move) begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_step && in_last_reg) begin
            fin_snap_reg <= snap;
        end
    end

    udprc_verify u_verify (
        .snap      (fin_snap_reg),
        .echo_port (echo_port_reg),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_move) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_verdict     = out_res_reg.verdict;
    assign m_source_port = out_res_reg.source_port;
    assign m_dest_port   = out_res_reg.dest_port;
    assign m_data_len    = out_res_reg.data_len;
    assign m_echo_hit    = out_res_reg.echo_hit;

endmodule

// File: rtl/udprc_checker.sv
// Port-level assertions for the UDP receive checker, bound to the top level.
// Depends on udprc_pkg and udp_receive_checker.
module udprc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_verdict,
    input logic [15:0] m_source_port,
    input logic [15:0] m_dest_port,
    input logic [15:0] m_data_len,
    input logic        m_echo_hit
);

    // A stalled result item holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_verdict) && $stable(m_data_len)))
        else $error("result item changed while stalled");

    // Only an accepted datagram may be flagged for echo.
    a_echo_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_echo_hit) |-> (m_verdict == udprc_pkg::VERDICT_ACCEPT))
        else $error("echo flag on a rejected datagram");

    // A runt reports no header fields.
    a_runt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_verdict == udprc_pkg::VERDICT_RUNT))
        |-> ((m_source_port == 16'd0) && (m_dest_port == 16'd0) && (m_data_len == 16'd0)))
        else $error("runt with nonzero fields");

    // A bad length field reports no payload length.
    a_badlen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_verdict == udprc_pkg::VERDICT_BAD_LEN)) |-> (m_data_len == 16'd0))
        else $error("bad length with nonzero payload length");

    // The payload length never exceeds the largest length field less the header.
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data_len <= (16'hFFFF - udprc_pkg::HDR_BYTES)))
        else $error("payload length out of range");

endmodule

bind udp_receive_checker udprc_checker u_udprc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_verdict     (m_verdict),
    .m_source_port (m_source_port),
    .m_dest_port   (m_dest_port),
    .m_data_len    (m_data_len),
    .m_echo_hit    (m_echo_hit)
);

// File: tb/udp_verdict_checker.sv
// Checker for the UDP receive checker: watches the config, byte and result
// channels, predicts each verdict item and compares it with what comes out.
// Depends on udprc_pkg for the verdict codes, header constants and result_t.
module udp_verdict_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_echo_port,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_verdict,
    input  logic [15:0] m_source_port,
    input  logic [15:0] m_dest_port,
    input  logic [15:0] m_data_len,
    input  logic        m_echo_hit,
    output int          mismatches,
    output int          outstanding
);

    // Predicted segment state and the echo port setting.
    logic [15:0] seg_pos;
    logic [15:0] sum_acc;
    logic [7:0]  held_high;
    logic [15:0] seen_source_port;
    logic [15:0] seen_dest_port;
    logic [15:0] seen_length;
    logic [15:0] seen_csum;
    logic [15:0] echo_setting;

    // Verdict items predicted but not yet seen on the result channel.
    udprc_pkg::result_t pending_verdicts[$];

    // Ones'-complement sum of two words with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + b;
        if (s[16])
            s = s[15:0] + 17'd1;
        return s[15:0];
    endfunction

    task automatic wipe_segment();
        seg_pos          = '0;
        sum_acc          = '0;
        held_high        = '0;
        seen_source_port = '0;
        seen_dest_port   = '0;
        seen_length      = '0;
        seen_csum        = '0;
    endtask

    // Fold one accepted byte into the segment state; a last byte yields a verdict.
    task automatic absorb_byte(input logic [31:0] sip, input logic [31:0] dip,
                               input logic [7:0] b, input logic last);
        logic [15:0]        idx;
        logic [7:0]         summed;
        logic [15:0]        acc;
        logic [15:0]        calc;
        udprc_pkg::result_t r;
        idx    = seg_pos;
        summed = b;
        case (idx)
            udprc_pkg::POS_SRC_HI:  seen_source_port[15:8] = b;
            udprc_pkg::POS_SRC_LO:  seen_source_port[7:0]  = b;
            udprc_pkg::POS_DST_HI:  seen_dest_port[15:8]   = b;
            udprc_pkg::POS_DST_LO:  seen_dest_port[7:0]    = b;
            udprc_pkg::POS_LEN_HI:  seen_length[15:8]      = b;
            udprc_pkg::POS_LEN_LO:  seen_length[7:0]       = b;
            udprc_pkg::POS_CSUM_HI: begin
                seen_csum[15:8] = b;
                summed = 8'h00;
            end
            udprc_pkg::POS_CSUM_LO: begin
                seen_csum[7:0] = b;
                summed = 8'h00;
            end
            default: ;
        endcase

        // Only the header and the first length-field bytes enter the sum.
        if (idx < udprc_pkg::HDR_BYTES || idx < seen_length) begin
            if (!idx[0])
                held_high = summed;
            else
                sum_acc = ones_add(sum_acc, {held_high, summed});
        end
        if (seg_pos != udprc_pkg::COUNT_MAX)
            seg_pos = seg_pos + 16'd1;
        if (!last)
            return;

        r = '0;
        if (seg_pos < udprc_pkg::HDR_BYTES) begin
            r.verdict = udprc_pkg::VERDICT_RUNT;
        end else begin
            r.source_port = seen_source_port;
            r.dest_port   = seen_dest_port;
            if (seen_length < udprc_pkg::HDR_BYTES || seen_length > seg_pos) begin
                r.verdict = udprc_pkg::VERDICT_BAD_LEN;
            end else begin
                r.data_len = seen_length - udprc_pkg::HDR_BYTES;
                r.verdict  = udprc_pkg::VERDICT_ACCEPT;
                // A zero checksum field means the sender did not compute one.
                if (seen_csum != 16'h0000) begin
                    acc = sum_acc;
                    if (seen_length[0])
                        acc = ones_add(acc, {held_high, 8'h00});
                    acc  = ones_add(acc, sip[31:16]);
                    acc  = ones_add(acc, sip[15:0]);
                    acc  = ones_add(acc, dip[31:16]);
                    acc  = ones_add(acc, dip[15:0]);
                    acc  = ones_add(acc, udprc_pkg::PROTO_UDP);
                    acc  = ones_add(acc, seen_length);
                    calc = ~acc;
                    if (!(calc == seen_csum || (calc == 16'h0000 && seen_csum == 16'hFFFF)))
                        r.verdict = udprc_pkg::VERDICT_BAD_CSUM;
                end
                r.echo_hit = (r.verdict == udprc_pkg::VERDICT_ACCEPT)
                          && (seen_dest_port == echo_setting);
            end
        end
        pending_verdicts.push_back(r);
        wipe_segment();
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Results are compared before the byte of the same edge is absorbed.
    always @(posedge aclk) begin
        udprc_pkg::result_t want;
        if (!aresetn) begin
            wipe_segment();
            echo_setting = udprc_pkg::ECHO_PORT_RESET;
            pending_verdicts.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                echo_setting = cfg_echo_port;
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, got verdict %0d",
                             $time, m_verdict);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    compare_field("verdict", 16'(want.verdict), 16'(m_verdict));
                    compare_field("source port", want.source_port, m_source_port);
                    compare_field("dest port", want.dest_port, m_dest_port);
                    compare_field("data_len", want.data_len, m_data_len);
                    compare_field("echo_hit", 16'(want.echo_hit), 16'(m_echo_hit));
                end
            end
            if (s_valid && s_ready)
                absorb_byte(s_src_ip, s_dst_ip, s_data_byte, s_last_byte);
        end
        outstanding = pending_verdicts.size();
    end

endmodule

// File: tb/tb_udp_receive_checker.sv
// Testbench top for the UDP receive checker: clock, reset, datagram stimulus,
// result-side backpressure, watchdog and the final verdict.
// Depends on udprc_pkg, udp_receive_checker and udp_verdict_checker.
module tb_udp_receive_checker;

    localparam int unsigned STALL_LIMIT     = 3000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned DRAIN_CYCLES    = 10;

    // Kinds of datagram the stimulus can build.
    typedef enum int {
        DG_GOOD,
        DG_ZERO_CSUM,
        DG_ALL_ONES_CSUM,
        DG_BAD_CSUM,
        DG_SHORT_LEN,
        DG_OVER_LEN,
        DG_RUNT
    } dg_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_echo_port;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_src_ip;
    logic [31:0] s_dst_ip;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_verdict;
    logic [15:0] m_source_port;
    logic [15:0] m_dest_port;
    logic [15:0] m_data_len;
    logic        m_echo_hit;

    int          mismatches;
    int          outstanding;
    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 60;
    int unsigned bytes_sent    = 0;
    int unsigned quiet_cycles  = 0;
    logic        hold_off_pending = 1'b0;
    logic [15:0] echo_now = udprc_pkg::ECHO_PORT_RESET;

    udp_receive_checker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_echo_port (cfg_echo_port),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_ip      (s_src_ip),
        .s_dst_ip      (s_dst_ip),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_source_port (m_source_port),
        .m_dest_port   (m_dest_port),
        .m_data_len    (m_data_len),
        .m_echo_hit    (m_echo_hit)
    );

    udp_verdict_checker verdict_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_echo_port (cfg_echo_port),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_ip      (s_src_ip),
        .s_dst_ip      (s_dst_ip),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_source_port (m_source_port),
        .m_dest_port   (m_dest_port),
        .m_data_len    (m_data_len),
        .m_echo_hit    (m_echo_hit),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte item, with random gaps before it, and wait until it is taken.
    task automatic send_byte(input logic [31:0] sip, input logic [31:0] dip,
                             input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_ip    <= sip;
        s_dst_ip    <= dip;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Build a datagram of the given kind and send it byte by byte. Only the
    // last byte carries the addresses that the checksum was computed over.
    // For a runt, plen is the number of bytes kept.
    task automatic send_datagram(input dg_kind_t kind, input int unsigned plen,
                                 input int unsigned extra, input logic [15:0] sport,
                                 input logic [15:0] dport);
        logic [7:0]  seg[$];
        logic [15:0] len_f;
        logic [15:0] fold16;
        logic [15:0] calc;
        logic [15:0] field;
        logic [15:0] fix;
        logic [31:0] sip;
        logic [31:0] dip;
        int unsigned tot;
        int unsigned i;
        int unsigned total_bytes;
        sip = $urandom;
        dip = $urandom;
        if (kind == DG_ALL_ONES_CSUM && plen < 2)
            plen = 2;
        len_f = 16'(udprc_pkg::HDR_BYTES + plen);
        seg.push_back(sport[15:8]);
        seg.push_back(sport[7:0]);
        seg.push_back(dport[15:8]);
        seg.push_back(dport[7:0]);
        seg.push_back(len_f[15:8]);
        seg.push_back(len_f[7:0]);
        seg.push_back(8'h00);
        seg.push_back(8'h00);
        repeat (plen) seg.push_back(8'($urandom));
        repeat (extra) seg.push_back(8'($urandom));
        if (kind == DG_ALL_ONES_CSUM) begin
            seg[8] = 8'h00;
            seg[9] = 8'h00;
        end

        // Plain 32-bit sum folded at the end.
        tot = sip[31:16] + sip[15:0] + dip[31:16] + dip[15:0] + udprc_pkg::PROTO_UDP + len_f;
        for (i = 0; i < len_f; i += 2)
            tot += {seg[i], (i + 1 < len_f) ? seg[i + 1] : 8'h00};
        while (tot > 32'h0000FFFF)
            tot = (tot & 32'h0000FFFF) + (tot >> 16);
        fold16 = tot[15:0];
        calc   = ~fold16;

        case (kind)
            DG_GOOD:      field = (calc == 16'h0000) ? 16'hFFFF : calc;
            DG_ZERO_CSUM: field = 16'h0000;
            DG_ALL_ONES_CSUM: begin
                // Pick the first payload word so that the computed checksum is zero.
                fix    = 16'hFFFF - fold16;
                seg[8] = fix[15:8];
                seg[9] = fix[7:0];
                field  = 16'hFFFF;
            end
            DG_BAD_CSUM: begin
                field = calc ^ (16'h0001 << $urandom_range(15));
                if (field == 16'h0000)
                    field = calc ^ 16'h0003;
            end
            DG_SHORT_LEN: begin
                len_f = 16'($urandom_range(7));
                field = 16'($urandom);
            end
            DG_OVER_LEN: begin
                len_f = 16'(seg.size() + $urandom_range(40, 1));
                field = 16'($urandom);
            end
            default: field = 16'($urandom);
        endcase
        seg[4] = len_f[15:8];
        seg[5] = len_f[7:0];
        seg[6] = field[15:8];
        seg[7] = field[7:0];
        if (kind == DG_RUNT) begin
            while (seg.size() > plen)
                void'(seg.pop_back());
        end

        total_bytes = seg.size();
        for (i = 0; i < total_bytes; i++) begin
            if (i == total_bytes - 1)
                send_byte(sip, dip, seg[i], 1'b1);
            else
                send_byte($urandom, $urandom, seg[i], 1'b0);
        end
        bytes_sent += total_bytes;
    endtask

    // Mostly well-formed datagrams with small payloads, the rest broken ones.
    task automatic random_datagram();
        int unsigned pick;
        int unsigned plen;
        int unsigned extra;
        dg_kind_t    kind;
        logic [15:0] dport;
        pick = $urandom_range(99);
        if (pick < 45)
            kind = DG_GOOD;
        else if (pick < 55)
            kind = DG_ZERO_CSUM;
        else if (pick < 63)
            kind = DG_ALL_ONES_CSUM;
        else if (pick < 75)
            kind = DG_BAD_CSUM;
        else if (pick < 83)
            kind = DG_SHORT_LEN;
        else if (pick < 91)
            kind = DG_OVER_LEN;
        else
            kind = DG_RUNT;
        plen  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
        extra = ($urandom_range(5) == 0) ? $urandom_range(4, 1) : 0;
        if (kind == DG_RUNT)
            plen = $urandom_range(7, 1);
        dport = ($urandom_range(3) == 0) ? echo_now : 16'($urandom);
        send_datagram(kind, plen, extra, 16'($urandom), dport);
    endtask

    task automatic run_until(input int unsigned target);
        while (bytes_sent < target)
            random_datagram();
    endtask

    // Change the echo port once every verdict is out and the pipeline is empty.
    task automatic change_echo_port(input logic [15:0] value);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid     <= 1'b1;
        cfg_echo_port <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        echo_now = value;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_echo_port = '0;
        s_valid       = 1'b0;
        s_src_ip      = '0;
        s_dst_ip      = '0;
        s_data_byte   = '0;
        s_last_byte   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one-byte runt, header-only datagram to the reset echo port,
        // odd length with no checksum, and a runt one byte short of a header.
        send_datagram(DG_RUNT, 1, 0, 16'hFFFF, 16'hFFFF);
        send_datagram(DG_GOOD, 0, 0, 16'hFFFF, udprc_pkg::ECHO_PORT_RESET);
        send_datagram(DG_ZERO_CSUM, 1, 0, 16'h0000, 16'h0000);
        send_datagram(DG_RUNT, 7, 0, 16'h0000, 16'h0000);

        // Random part in three idle mixes, with a different echo port in each.
        run_until(350);
        change_echo_port(16'hFFFF);
        send_idle_pct = 60;
        recv_idle_pct = 21;
        run_until(700);
        change_echo_port(16'h0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_pending = 1'b1;
        run_until(1050);

        // A random echo port and a few more datagrams to finish.
        change_echo_port(16'($urandom));
        repeat (4) random_datagram();

        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
